// ----- rtl/multiphase_sine_lfo_core_assert.svh -----
// multiphase_sine_lfo_core_assert.svh: assertion macros for the lfo checker
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef MULTIPHASE_SINE_LFO_CORE_ASSERT_SVH
`define MULTIPHASE_SINE_LFO_CORE_ASSERT_SVH

// always active, also during reset
`define MSLFO_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// active only out of reset
`define MSLFO_CHECK_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ----- rtl/mslfo_pkg.sv -----
// mslfo_pkg: types, constants and table functions of the multiphase sine lfo
// no dependencies
`timescale 1ns / 1ps

package mslfo_pkg;

    localparam int CFG_ADDR_W     = 8;
    localparam int CFG_DATA_W     = 32;
    localparam int PHASE_W        = 32;
    localparam int VALUE_W        = 16;
    localparam int CHAN_W         = 3;
    localparam int NCH_W          = 4;
    localparam int MAG_W          = 15;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 24;
    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic [PHASE_W-1:0]    RST_PHASE_INC = '0;
    localparam logic signed [VALUE_W-1:0] RST_MIN   = 16'sd0;
    localparam logic signed [VALUE_W-1:0] RST_MAX   = 16'sd32767;
    localparam logic [NCH_W-1:0]      RST_NCH       = 4'd2;

    localparam logic [63:0] C1_Q30 = 64'd1686629713;
    localparam logic [63:0] C3_Q30 = 64'd693598668;
    localparam logic [63:0] C5_Q30 = 64'd85569306;
    localparam logic [63:0] C7_Q30 = 64'd5026995;
    localparam logic [63:0] C9_Q30 = 64'd172272;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PHASE_INC = 8'd0,
        REG_MIN_VALUE = 8'd1,
        REG_MAX_VALUE = 8'd2,
        REG_NUM_CHAN  = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PHASE_W-1:0] base;
        logic [NCH_W-1:0]   n;
        logic               rst;
    } t_job;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_v;
        logic signed [VALUE_W-1:0] max_v;
    } t_scale;

    typedef struct packed {
        logic                      rst;
        logic                      last;
        logic signed [VALUE_W-1:0] value;
        logic [CHAN_W-1:0]         ch;
    } t_item;

    typedef struct packed {
        logic [PHASE_W-1:0] step;
        logic [NCH_W-1:0]   rem;
    } t_step;

    // floor(2^32 / n) and 2^32 mod n
    function automatic t_step offset_step(input logic [NCH_W-1:0] n);
        t_step s;
        unique case (n)
            4'd0:  s = '{32'h0000_0000, 4'd0};
            4'd1:  s = '{32'h0000_0000, 4'd0};
            4'd2:  s = '{32'h8000_0000, 4'd0};
            4'd3:  s = '{32'h5555_5555, 4'd1};
            4'd4:  s = '{32'h4000_0000, 4'd0};
            4'd5:  s = '{32'h3333_3333, 4'd1};
            4'd6:  s = '{32'h2AAA_AAAA, 4'd4};
            4'd7:  s = '{32'h2492_4924, 4'd4};
            4'd8:  s = '{32'h2000_0000, 4'd0};
            4'd9:  s = '{32'h1C71_C71C, 4'd4};
            4'd10: s = '{32'h1999_9999, 4'd6};
            4'd11: s = '{32'h1745_D174, 4'd4};
            4'd12: s = '{32'h1555_5555, 4'd4};
            4'd13: s = '{32'h13B1_3B13, 4'd9};
            4'd14: s = '{32'h1249_2492, 4'd4};
            4'd15: s = '{32'h1111_1111, 4'd1};
            default: s = '{32'h0000_0000, 4'd0};
        endcase
        return s;
    endfunction

    // quarter-wave magnitude in Q0.15, used only to build the sine rom
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned pos,
                                                  input int unsigned qbits);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] r;
        logic [63:0] mag;
        z   = 64'(pos) << (30 - qbits);
        z2  = (z * z) >> 30;
        r   = C9_Q30;
        r   = C7_Q30 - ((z2 * r) >> 30);
        r   = C5_Q30 - ((z2 * r) >> 30);
        r   = C3_Q30 - ((z2 * r) >> 30);
        r   = C1_Q30 - ((z2 * r) >> 30);
        r   = (z * r) >> 30;
        mag = (r + 64'd16384) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return mag[MAG_W-1:0];
    endfunction

endpackage

// ----- rtl/mslfo_front.sv -----
// mslfo_front: configuration registers, tick intake and base phase tracking
// depends on mslfo_pkg; feeds jobs to mslfo_job_queue
`timescale 1ns / 1ps

module mslfo_front #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mslfo_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mslfo_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_tick_valid,
    output logic                               o_tick_ready,
    input  logic                               i_tick_rst,
    output logic                               o_job_valid,
    input  logic                               i_job_ready,
    output mslfo_pkg::t_job                    o_job,
    output mslfo_pkg::t_scale                  o_scale
);
    import mslfo_pkg::*;

    logic [PHASE_W-1:0]        r_inc;
    logic signed [VALUE_W-1:0] r_min;
    logic signed [VALUE_W-1:0] r_max;
    logic [NCH_W-1:0]          r_nch;
    logic [PHASE_W-1:0]        r_base;
    logic [PHASE_W-1:0]        n_base;
    logic [PHASE_W-1:0]        w_start;
    logic [NCH_W-1:0]          w_n;
    logic                      w_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= RST_PHASE_INC;
            r_min <= RST_MIN;
            r_max <= RST_MAX;
            r_nch <= RST_NCH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_PHASE_INC: r_inc <= i_cfg_data[PHASE_W-1:0];
                REG_MIN_VALUE: r_min <= i_cfg_data[VALUE_W-1:0];
                REG_MAX_VALUE: r_max <= i_cfg_data[VALUE_W-1:0];
                REG_NUM_CHAN:  r_nch <= i_cfg_data[NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // channel count: zero means one, clamp to the build maximum
    always_comb begin
        if (r_nch == '0) begin
            w_n = NCH_W'(1);
        end else if (int'(r_nch) > MAX_CHANNELS) begin
            w_n = NCH_W'(MAX_CHANNELS);
        end else begin
            w_n = r_nch;
        end
    end

    assign o_tick_ready = i_job_ready;
    assign o_job_valid  = i_tick_valid;
    assign w_take       = i_tick_valid && i_job_ready;
    assign w_start      = i_tick_rst ? '0 : r_base;
    assign n_base       = w_take ? (w_start + r_inc) : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else begin
            r_base <= n_base;
        end
    end

    assign o_job.base    = w_start;
    assign o_job.n       = w_n;
    assign o_job.rst     = i_tick_rst;
    assign o_scale.min_v = r_min;
    assign o_scale.max_v = r_max;

endmodule

// ----- rtl/mslfo_job_queue.sv -----
// mslfo_job_queue: two-entry queue of tick jobs between front and back
// depends on mslfo_pkg
`timescale 1ns / 1ps

module mslfo_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  mslfo_pkg::t_job i_push_job,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output mslfo_pkg::t_job o_pop_job
);
    import mslfo_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_job    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

// ----- rtl/mslfo_back.sv -----
// mslfo_back: channel sequencer, sine rom, scaling multiplier and result fifo
// depends on mslfo_pkg; takes jobs from mslfo_job_queue
`timescale 1ns / 1ps

module mslfo_back #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  mslfo_pkg::t_job   i_job,
    input  mslfo_pkg::t_scale i_scale,
    output logic              o_item_valid,
    input  logic              i_item_ready,
    output mslfo_pkg::t_item  o_item
);
    import mslfo_pkg::*;

    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int QLEN  = 1 << QBITS;
    localparam int POS_W = SINE_TABLE_BITS - 1;
    localparam int FP_W  = $clog2(OUT_FIFO_DEPTH);
    localparam int FC_W  = $clog2(OUT_FIFO_DEPTH + 1);

    typedef logic [MAG_W-1:0] t_rom [QLEN+1];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i <= QLEN; i++) begin
            rom[i] = sine_mag(i, QBITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } t_seq_state;

    t_seq_state         r_state;
    t_seq_state         n_state;
    t_job               r_job;
    logic [NCH_W-1:0]   r_c;
    logic [PHASE_W-1:0] r_off;
    logic [NCH_W-1:0]   r_rem;
    logic [NCH_W-1:0]   n_rem;
    logic [PHASE_W-1:0] n_off;
    t_step              w_step;
    logic [NCH_W:0]     w_rsum;
    logic               w_carry;
    logic               w_load;
    logic               w_issue;
    logic               w_last;
    logic [FC_W:0]      w_occ;

    // stage 0: channel phase
    logic               r0_vld;
    logic [PHASE_W-1:0] r0_ph;
    logic [CHAN_W-1:0]  r0_ch;
    logic               r0_last;
    logic               r0_rst;
    // stage 1: rom magnitude
    logic               r1_vld;
    logic [MAG_W-1:0]   r1_mag;
    logic               r1_neg;
    logic [CHAN_W-1:0]  r1_ch;
    logic               r1_last;
    logic               r1_rst;
    // stage 2: scaled product
    logic               r2_vld;
    logic signed [33:0] r2_prod;
    logic [CHAN_W-1:0]  r2_ch;
    logic               r2_last;
    logic               r2_rst;

    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]                 w_quad;
    logic [QBITS-1:0]           w_w;
    logic [POS_W-1:0]           w_pos;
    logic signed [16:0]         w_sine;
    logic signed [16:0]         w_u;
    logic signed [16:0]         w_range;
    logic signed [33:0]         w_rnd;
    logic signed [18:0]         w_sum;
    logic signed [VALUE_W-1:0]  w_value;

    t_item             r_fifo [OUT_FIFO_DEPTH];
    logic [FP_W-1:0]   r_wp;
    logic [FP_W-1:0]   r_rp;
    logic [FC_W-1:0]   r_ocnt;
    logic [FC_W-1:0]   n_ocnt;
    logic              w_rd;
    t_item             w_item;

    // sequencer
    assign w_occ   = (FC_W+1)'(r_ocnt) + (FC_W+1)'(r0_vld) + (FC_W+1)'(r1_vld)
                   + (FC_W+1)'(r2_vld);
    assign w_load  = (r_state == SEQ_IDLE) && i_job_valid;
    assign w_issue = (r_state == SEQ_RUN) && (w_occ < (FC_W+1)'(OUT_FIFO_DEPTH));
    assign w_last  = (r_c == (r_job.n - NCH_W'(1)));
    assign o_job_ready = (r_state == SEQ_IDLE);

    assign w_step  = offset_step(r_job.n);
    assign w_rsum  = {1'b0, r_rem} + {1'b0, w_step.rem};
    assign w_carry = (w_rsum >= {1'b0, r_job.n});
    assign n_rem   = w_carry ? NCH_W'(w_rsum - {1'b0, r_job.n}) : w_rsum[NCH_W-1:0];
    assign n_off   = r_off + w_step.step + PHASE_W'(w_carry);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: if (i_job_valid) n_state = SEQ_RUN;
            SEQ_RUN:  if (w_issue && w_last) n_state = SEQ_IDLE;
            default:  n_state = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r0_vld  <= 1'b0;
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r0_vld  <= w_issue;
            r1_vld  <= r0_vld;
            r2_vld  <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job;
            r_c   <= '0;
            r_off <= '0;
            r_rem <= '0;
        end else if (w_issue) begin
            r_c   <= r_c + NCH_W'(1);
            r_off <= n_off;
            r_rem <= n_rem;
        end
    end

    // pipeline payload
    assign w_idx  = r0_ph[PHASE_W-1 -: SINE_TABLE_BITS];
    assign w_quad = w_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_w    = w_idx[QBITS-1:0];
    assign w_pos  = w_quad[0] ? (POS_W'(QLEN) - {1'b0, w_w}) : {1'b0, w_w};

    assign w_sine  = r1_neg ? -$signed({2'b00, r1_mag}) : $signed({2'b00, r1_mag});
    assign w_u     = 17'sd32768 + w_sine;
    assign w_range = 17'(i_scale.max_v) - 17'(i_scale.min_v);

    assign w_rnd = r2_prod + 34'sd32768;
    assign w_sum = 19'(i_scale.min_v) + 19'($signed(w_rnd[33:16]));

    always_comb begin
        if (w_sum > 19'sd32767) begin
            w_value = 16'sd32767;
        end else if (w_sum < -19'sd32768) begin
            w_value = -16'sd32768;
        end else begin
            w_value = w_sum[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r0_ph   <= r_job.base + r_off;
        r0_ch   <= r_c[CHAN_W-1:0];
        r0_last <= w_last;
        r0_rst  <= r_job.rst;
        r1_mag  <= SINE_ROM[w_pos];
        r1_neg  <= w_quad[1];
        r1_ch   <= r0_ch;
        r1_last <= r0_last;
        r1_rst  <= r0_rst;
        r2_prod <= 34'(w_range) * 34'(w_u);
        r2_ch   <= r1_ch;
        r2_last <= r1_last;
        r2_rst  <= r1_rst;
    end

    // result fifo, space reserved at issue
    assign w_item.rst   = r2_rst;
    assign w_item.last  = r2_last;
    assign w_item.value = w_value;
    assign w_item.ch    = r2_ch;

    assign o_item_valid = (r_ocnt != '0);
    assign o_item       = r_fifo[r_rp];
    assign w_rd         = o_item_valid && i_item_ready;

    always_comb begin
        n_ocnt = r_ocnt;
        if (r2_vld && !w_rd) begin
            n_ocnt = r_ocnt + FC_W'(1);
        end else if (w_rd && !r2_vld) begin
            n_ocnt = r_ocnt - FC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_ocnt <= '0;
        end else begin
            r_ocnt <= n_ocnt;
            if (r2_vld) begin
                r_wp <= r_wp + FP_W'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + FP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_vld) begin
            r_fifo[r_wp] <= w_item;
        end
    end

endmodule

// ----- rtl/multiphase_sine_lfo_core.sv -----
// Multiphase sine lfo. Each input item is one sample tick; it yields one result item per
// channel, channel 0 first, the last one marked with tlast. A tick is first loaded into
// the channel sequencer, which then issues its channels in turn, holding while the result
// fifo has no free space; it loads the next tick only after the last channel, since all
// channels share the single sine rom and scaling multiplier. Ticks are taken into a
// two-entry queue while earlier ones still run, and up to eight results wait in an output
// fifo. Configuration writes are taken in any cycle and must only be made while no tick is
// in progress.
// depends on mslfo_pkg, mslfo_front, mslfo_job_queue, mslfo_back
`timescale 1ns / 1ps

module multiphase_sine_lfo_core #(
    parameter int MAX_CHANNELS    = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mslfo_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [mslfo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mslfo_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] reset_phase
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mslfo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [2:0] channel, [18:3] value
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser    // [0] reset_echo
);
    import mslfo_pkg::*;

    logic   w_fq_valid;
    logic   w_fq_ready;
    t_job   w_fq_job;
    logic   w_qb_valid;
    logic   w_qb_ready;
    t_job   w_qb_job;
    t_scale w_scale;
    t_item  w_item;

    mslfo_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_tick_valid (s_axis_tvalid),
        .o_tick_ready (s_axis_tready),
        .i_tick_rst   (s_axis_tdata[0]),
        .o_job_valid  (w_fq_valid),
        .i_job_ready  (w_fq_ready),
        .o_job        (w_fq_job),
        .o_scale      (w_scale)
    );

    mslfo_job_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_job   (w_fq_job),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_job    (w_qb_job)
    );

    mslfo_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_qb_valid),
        .o_job_ready  (w_qb_ready),
        .i_job        (w_qb_job),
        .i_scale      (w_scale),
        .o_item_valid (m_axis_tvalid),
        .i_item_ready (m_axis_tready),
        .o_item       (w_item)
    );

    assign m_axis_tdata = {5'b00000, w_item.value, w_item.ch};
    assign m_axis_tlast = w_item.last;
    assign m_axis_tuser = w_item.rst;

endmodule

// ----- rtl/mslfo_checker.sv -----
// mslfo_checker: port-level assertions for multiphase_sine_lfo_core, bound to it below
// depends on multiphase_sine_lfo_core_assert.svh
`timescale 1ns / 1ps
`include "multiphase_sine_lfo_core_assert.svh"

module mslfo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // reset empties the result fifo
    `MSLFO_CHECK(a_rst_clears_out, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    `MSLFO_CHECK_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled item changed")

    // pad bits above the value stay zero
    `MSLFO_CHECK_RUN(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0, "tdata pad bits set")

endmodule

bind multiphase_sine_lfo_core mslfo_checker u_mslfo_checker (.*);

// ----- tb/sv/tb_multiphase_sine_lfo_core.sv -----
// tb_multiphase_sine_lfo_core: self-checking bench for the multiphase sine lfo core
// a tick tracker class predicts every channel value and checks the output stream in order
// depends on mslfo_pkg and multiphase_sine_lfo_core
`timescale 1ns / 1ps

module tb_multiphase_sine_lfo_core;
    import mslfo_pkg::*;

    localparam int MAX_CH      = 8;
    localparam int TABLE_BITS  = 10;
    localparam int WATCHDOG    = 5000;
    localparam int SETTLE      = 16;
    localparam int PHASE_TICKS = 18;
    localparam int LONG_HOLD   = 200;

    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 8'hC3;

    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598668;
    localparam longint unsigned K5 = 64'd85569306;
    localparam longint unsigned K7 = 64'd5026995;
    localparam longint unsigned K9 = 64'd172272;

    typedef struct packed {
        logic [CHAN_W-1:0]         ch;
        logic signed [VALUE_W-1:0] value;
        logic                      echo;
        logic                      last;
    } t_lfo_sample;

    class lfo_tracker;
        logic [PHASE_W-1:0]        phase_step;
        logic signed [VALUE_W-1:0] trough;
        logic signed [VALUE_W-1:0] peak;
        logic [NCH_W-1:0]          chan_count;
        logic [PHASE_W-1:0]        base;
        t_lfo_sample               pending[$];
        int                        mismatches;
        int                        checked;

        function new();
            phase_step = '0;
            trough     = 16'sd0;
            peak       = 16'sd32767;
            chan_count = 4'd2;
            base       = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PHASE_INC: phase_step = data;
                REG_MIN_VALUE: trough     = data[15:0];
                REG_MAX_VALUE: peak       = data[15:0];
                REG_NUM_CHAN:  chan_count = data[3:0];
                default: ;
            endcase
        endfunction

        function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
            return (a * b) >> 30;
        endfunction

        function int sine_q15(logic [PHASE_W-1:0] ph);
            int unsigned     idx;
            int unsigned     quad;
            int unsigned     w;
            int unsigned     pos;
            longint unsigned z;
            longint unsigned z2;
            longint unsigned r;
            longint unsigned mag;
            idx  = ph >> (32 - TABLE_BITS);
            quad = (idx >> (TABLE_BITS - 2)) & 3;
            w    = idx & ((1 << (TABLE_BITS - 2)) - 1);
            pos  = (quad & 1) ? (1 << (TABLE_BITS - 2)) - w : w;
            z    = longint'(pos) << (30 - (TABLE_BITS - 2));
            z2   = q30_mul(z, z);
            r    = K7 - q30_mul(z2, K9);
            r    = K5 - q30_mul(z2, r);
            r    = K3 - q30_mul(z2, r);
            r    = K1 - q30_mul(z2, r);
            r    = q30_mul(z, r);
            mag  = (r + 64'd16384) >> 15;
            if (mag > 64'd32767) begin
                mag = 64'd32767;
            end
            return (quad & 2) ? -int'(mag) : int'(mag);
        endfunction

        function logic signed [VALUE_W-1:0] scale(int s);
            longint span;
            longint u;
            longint prod;
            longint v;
            span = longint'(peak) - longint'(trough);
            u    = 32768 + s;
            prod = span * u + 32768;
            v    = longint'(trough) + (prod >>> 16);
            if (v > 32767) begin
                v = 32767;
            end
            if (v < -32768) begin
                v = -32768;
            end
            return v[15:0];
        endfunction

        function void take_tick(logic clear);
            int unsigned     n;
            longint unsigned off;
            t_lfo_sample     smp;
            n = chan_count;
            if (n == 0) begin
                n = 1;
            end
            if (n > MAX_CH) begin
                n = MAX_CH;
            end
            if (clear) begin
                base = '0;
            end
            for (int unsigned c = 0; c < n; c++) begin
                off       = (longint'(c) << 32) / n;
                smp.ch    = c[CHAN_W-1:0];
                smp.value = scale(sine_q15(base + off[31:0]));
                smp.echo  = clear;
                smp.last  = (c + 1 == n);
                pending.push_back(smp);
            end
            base = base + phase_step;
        endfunction

        function void check_sample(t_lfo_sample got);
            t_lfo_sample want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: ch %0d value %0d echo %0b last %0b",
                             got.ch, got.value, got.echo, got.last);
                end
                return;
            end
            want = pending.pop_front();
            if (got.ch !== want.ch || got.value !== want.value ||
                got.echo !== want.echo || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected ch %0d value %0d echo %0b last %0b, got ch %0d value %0d echo %0b last %0b",
                             want.ch, want.value, want.echo, want.last,
                             got.ch, got.value, got.echo, got.last);
                end
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    lfo_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int ticks_sent     = 0;
    int regs_written   = 0;

    multiphase_sine_lfo_core #(
        .MAX_CHANNELS    (MAX_CH),
        .SINE_TABLE_BITS (TABLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [0] reset_phase
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [2:0] channel, [18:3] value
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)     // [0] reset_echo
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_sample('{m_axis_tdata[2:0], m_axis_tdata[18:3],
                                       m_axis_tuser, m_axis_tlast});
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ticks_sent++;
                tracker.take_tick(s_axis_tdata[0]);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                regs_written++;
                tracker.apply_reg(i_cfg_addr, i_cfg_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no item moved for %0d cycles, %0d results pending",
                     quiet_cycles, tracker.pending.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic program_reg(input logic [CFG_ADDR_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic setup_lfo(input logic [31:0] step, input logic signed [15:0] lo,
                             input logic signed [15:0] hi, input logic [3:0] n);
        program_reg(REG_PHASE_INC, step);
        program_reg(REG_MIN_VALUE, {16'($urandom), lo});
        program_reg(REG_MAX_VALUE, {16'($urandom), hi});
        program_reg(REG_NUM_CHAN, {28'($urandom), n});
    endtask

    function automatic logic signed [15:0] pick_level();
        case ($urandom_range(3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 1 << 24);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_tick(input logic clear);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, clear};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit squeeze);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < 2; k++) begin
            if ($urandom_range(3) == 0) begin
                program_reg(REG_UNMAPPED, $urandom);
            end
            setup_lfo(pick_step(), pick_level(), pick_level(), 4'($urandom_range(15)));
            if (squeeze && k == 0) begin
                @(posedge i_clk);
                hold_left = LONG_HOLD;
            end
            for (int t = 0; t < PHASE_TICKS; t++) begin
                send_tick($urandom_range(99) < 10);
            end
            drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: two channels, no phase advance
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // full-scale swing on eight channels, clears mid-run
        setup_lfo(32'h0400_0000, 16'sh8000, 16'sh7FFF, 4'd8);
        send_tick(1'b1);
        for (int t = 0; t < 7; t++) begin
            send_tick(t == 4);
        end
        drain();

        // single channel, inverted wave, step of almost a whole cycle
        setup_lfo(32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 4'd1);
        for (int t = 0; t < 4; t++) begin
            send_tick(t == 0);
        end
        drain();

        // zero channel count acts as one, counts above eight saturate
        setup_lfo(32'h1234_5678, -16'sd1000, 16'sd20000, 4'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        drain();
        program_reg(REG_NUM_CHAN, {28'hFFF_FFFF, 4'd15});
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // unmapped register is ignored, flat output with min equal to max
        program_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        setup_lfo(32'h8000_0000, 16'sd5, 16'sd5, 4'd3);
        for (int t = 0; t < 3; t++) begin
            send_tick(1'b0);
        end
        drain();

        setup_lfo(32'h8000_0000, -16'sd100, 16'sd100, 4'd7);
        for (int t = 0; t < 3; t++) begin
            send_tick(t == 2);
        end
        drain();

        run_phase(0, 0, 1'b1);
        run_phase(69, 0, 1'b0);
        run_phase(0, 69, 1'b0);
        run_phase(13, 13, 1'b0);
        recv_stall_pct = 0;

        $display("run covered %0d ticks, %0d channel items, %0d register writes",
                 ticks_sent, tracker.checked, regs_written);
        $display("channel counts 0 to 15, inverted and flat ranges, clears and a long output stall");
        if (tracker.pending.size() != 0) begin
            tracker.mismatches += tracker.pending.size();
            $display("%0d expected items never arrived", tracker.pending.size());
        end
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mslfo_pkg.sv
rtl/mslfo_front.sv
rtl/mslfo_job_queue.sv
rtl/mslfo_back.sv
rtl/multiphase_sine_lfo_core.sv
rtl/mslfo_checker.sv
tb/sv/tb_multiphase_sine_lfo_core.sv
